// ----- hw/rtl/dtpy_pkg.sv -----
// ----------------------------------------------------------------------------
// dtpy_pkg - shared types and constants for direction_to_pitch_yaw
// Datapath widths, CORDIC gain constant and the per-stage arctangent table
// generator used by the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package dtpy_pkg;

  // difference of two 32-bit coordinates
  localparam int DIFF_W  = 33;
  // CORDIC x/y datapath
  localparam int XY_W    = 64;
  // angle accumulator, degrees in Q30 (|angle| < 100 deg)
  localparam int ZW      = 40;
  // differences are scaled up by this many guard bits
  localparam int GUARD   = 24;
  // CORDIC gain limit in Q30, split for two narrow multipliers
  localparam logic [30:0] KQ30 = 31'd1768195363;
  localparam logic [63:0] DEG_PER_RAD_Q24 = 64'd961263669;

  localparam int PITCH_W = 24;
  localparam int YAW_W   = 26;

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [ZW-1:0]   ang_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  // flags that ride along with an item
  typedef struct packed {
    logic dz_neg;
    logic degen;
    logic zero_h;
    logic dy_neg;
  } flags_t;

  // atan(2^-i) in degrees, Q30; worked out at elaboration only
  function automatic logic [63:0] atan_deg_q30(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int          e;
    acc = 64'd0;
    if (i == 0) begin
      return 64'd45 << 30;
    end
    for (int k = 0; k < 63; k++) begin
      e = 62 - (2 * k + 1) * i;
      if (e >= 0) begin
        term = (64'd1 << e) / 64'(2 * k + 1);
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return ((acc >> 28) * DEG_PER_RAD_Q24) >> 28;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dtpy_front.sv -----
// ----------------------------------------------------------------------------
// dtpy_front - difference vector and CORDIC operand preparation
// Two register stages: exact differences, then scaled operands, flags and
// the two partial products of K*dy.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpy_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 v_i,
  input  wire logic [191:0]         pts_i,   // from_x, from_y, from_z, to_x, to_y, to_z
  output logic                      v_o,
  output dtpy_pkg::xy_t             x_o,
  output dtpy_pkg::xy_t             y_o,
  output dtpy_pkg::xy_t             ky_o,
  output dtpy_pkg::flags_t          flg_o
);
  import dtpy_pkg::*;

  logic               v1_r;
  diff_t              dx_r, dy_r, dz_r;
  logic               v2_r;
  xy_t                x_r, y_r;
  logic signed [49:0] p0_r;
  logic signed [48:0] p1_r;
  flags_t             flg_r;

  diff_t              dx_nxt, dy_nxt, dz_nxt;
  logic signed [33:0] adz;

  // exact 33-bit differences
  always_comb begin
    dx_nxt = $signed({pts_i[127], pts_i[127:96]}) - $signed({pts_i[31], pts_i[31:0]});
    dy_nxt = $signed({pts_i[159], pts_i[159:128]}) - $signed({pts_i[63], pts_i[63:32]});
    dz_nxt = $signed({pts_i[191], pts_i[191:160]}) - $signed({pts_i[95], pts_i[95:64]});
    adz    = dz_r[DIFF_W-1] ? -34'(dz_r) : 34'(dz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_i;
      v2_r <= v1_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r         <= dx_nxt;
      dy_r         <= dy_nxt;
      dz_r         <= dz_nxt;
      x_r          <= XY_W'(adz) <<< GUARD;
      y_r          <= XY_W'(dx_r) <<< GUARD;
      p0_r         <= dy_r * $signed({1'b0, KQ30[15:0]});
      p1_r         <= dy_r * $signed({1'b0, KQ30[30:16]});
      flg_r.dz_neg <= dz_r[DIFF_W-1];
      flg_r.degen  <= (dx_r == '0) && (dy_r == '0) && (dz_r == '0);
      flg_r.zero_h <= (dx_r == '0) && (dz_r == '0);
      flg_r.dy_neg <= dy_r[DIFF_W-1];
    end
  end

  // K*dy, floor-shifted down to the guard scale
  assign ky_o  = ((XY_W'(p1_r) <<< 16) + XY_W'(p0_r)) >>> (30 - GUARD);
  assign v_o   = v2_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign flg_o = flg_r;

endmodule

`default_nettype wire

// ----- hw/rtl/dtpy_cell.sv -----
// ----------------------------------------------------------------------------
// dtpy_cell - one vectoring CORDIC micro-rotation
// Rotates (x, y) towards the x axis by atan(2^-STAGE), accumulates the angle
// and hands everything to the next cell each cycle in which en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpy_cell #(
  parameter int STAGE = 0,
  parameter int PW    = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            v_i,
  input  dtpy_pkg::xy_t        x_i,
  input  dtpy_pkg::xy_t        y_i,
  input  dtpy_pkg::ang_t       z_i,
  input  wire logic [PW-1:0]   pay_i,
  output logic                 v_o,
  output dtpy_pkg::xy_t        x_o,
  output dtpy_pkg::xy_t        y_o,
  output dtpy_pkg::ang_t       z_o,
  output logic [PW-1:0]        pay_o
);
  import dtpy_pkg::*;

  localparam ang_t ANG = ZW'(atan_deg_q30(STAGE));

  logic        v_r;
  xy_t         x_r, y_r;
  ang_t        z_r;
  logic [PW-1:0] pay_r;

  xy_t  xs, ys;
  logic up;

  assign xs = x_i >>> STAGE;
  assign ys = y_i >>> STAGE;
  assign up = !y_i[XY_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  // micro-rotation
  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= up ? x_i + ys : x_i - ys;
      y_r   <= up ? y_i - xs : y_i + xs;
      z_r   <= up ? z_i + ANG : z_i - ANG;
      pay_r <= pay_i;
    end
  end

  assign v_o   = v_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;
  assign pay_o = pay_r;

endmodule

`default_nettype wire

// ----- hw/rtl/dtpy_finish.sv -----
// ----------------------------------------------------------------------------
// dtpy_finish - angle rounding, clamping, mirroring and special cases
// Turns the two Q30 CORDIC angles into the output pitch and yaw fields.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpy_finish #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  dtpy_pkg::ang_t                  ya_i,
  input  dtpy_pkg::ang_t                  ea_i,
  input  dtpy_pkg::flags_t                flg_i,
  output logic [dtpy_pkg::PITCH_W-1:0]    pitch_o,
  output logic [dtpy_pkg::YAW_W-1:0]      yaw_o
);
  import dtpy_pkg::*;

  localparam int   SH    = 30 - ANGLE_FRAC_BITS;
  localparam ang_t LIM   = ZW'(90) <<< ANGLE_FRAC_BITS;
  localparam ang_t HALFC = ZW'(180) <<< ANGLE_FRAC_BITS;
  localparam ang_t HALF  = ZW'(1) <<< (SH - 1);

  ang_t yr, er, yc, ec, pitch, yaw;

  always_comb begin
    // round half up, then clamp to +/-90 degrees
    yr = (ya_i + HALF) >>> SH;
    er = (ea_i + HALF) >>> SH;
    yc = (yr > LIM) ? LIM : ((yr < -LIM) ? -LIM : yr);
    ec = (er > LIM) ? LIM : ((er < -LIM) ? -LIM : er);
    pitch = -ec;
    yaw   = flg_i.dz_neg ? -HALFC - yc : yc;
    // straight up or down, and the zero vector
    if (flg_i.degen) begin
      pitch = '0;
      yaw   = '0;
    end else if (flg_i.zero_h) begin
      pitch = flg_i.dy_neg ? LIM : -LIM;
      yaw   = '0;
    end
    pitch_o = pitch[PITCH_W-1:0];
    yaw_o   = yaw[YAW_W-1:0];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/direction_to_pitch_yaw.sv -----
// ----------------------------------------------------------------------------
// direction_to_pitch_yaw - pitch and yaw of the direction between two points
// Difference vector, two chains of vectoring CORDIC cells and an output
// register with a skid stage.
// ----------------------------------------------------------------------------
// One point pair is taken per cycle while in_tready is high, and each gives
// one result after two preparation stages, the yaw chain, the pitch chain and
// the output register. Each cell does one micro-rotation per cycle while
// in_tready is high. Angles are degrees in Q.ANGLE_FRAC_BITS; out_tuser flags
// the zero vector, with both angles 0.
`default_nettype none

module direction_to_pitch_yaw #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STAGES   = 24
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [191:0] in_tdata,   // from_x, from_y, from_z, to_x, to_y, to_z
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [55:0]       out_tdata,  // pitch_deg[23:0], yaw_deg[49:24], zero pad
  output logic [0:0]        out_tuser   // degenerate
);
  import dtpy_pkg::*;

  localparam int NS  = CORDIC_STAGES;
  localparam int FW  = $bits(flags_t);
  localparam int PW1 = XY_W + FW;
  localparam int PW2 = ZW + FW;

  logic en;

  // yaw chain wiring
  logic            v1 [0:NS];
  xy_t             x1 [0:NS];
  xy_t             y1 [0:NS];
  ang_t            z1 [0:NS];
  logic [PW1-1:0]  p1 [0:NS];
  // pitch chain wiring
  logic            v2 [0:NS];
  xy_t             x2 [0:NS];
  xy_t             y2 [0:NS];
  ang_t            z2 [0:NS];
  logic [PW2-1:0]  p2 [0:NS];

  xy_t    ky0, ky_end;
  flags_t flg0, flg1, flg2;
  ang_t   ya_end;

  logic [PITCH_W-1:0] pitch;
  logic [YAW_W-1:0]   yaw;

  logic              out_v_r, skid_v_r;
  logic [55:0]       out_d_r, skid_d_r;
  logic              out_u_r, skid_u_r;
  logic [55:0]       res_d;

  assign en        = !skid_v_r;
  assign in_tready = en;

  dtpy_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (in_tvalid),
    .pts_i (in_tdata),
    .v_o   (v1[0]),
    .x_o   (x1[0]),
    .y_o   (y1[0]),
    .ky_o  (ky0),
    .flg_o (flg0)
  );
  assign z1[0] = '0;
  assign p1[0] = {ky0, flg0};

  for (genvar i = 0; i < NS; i++) begin : g_yaw
    dtpy_cell #(.STAGE(i), .PW(PW1)) u_cell (
      .clk (clk), .rst_n (rst_n), .en (en),
      .v_i (v1[i]), .x_i (x1[i]), .y_i (y1[i]), .z_i (z1[i]), .pay_i (p1[i]),
      .v_o (v1[i+1]), .x_o (x1[i+1]), .y_o (y1[i+1]), .z_o (z1[i+1]),
      .pay_o (p1[i+1])
    );
  end

  // hand over: K*h and K*dy enter the pitch chain
  assign ky_end = p1[NS][PW1-1:FW];
  assign flg1   = p1[NS][FW-1:0];
  assign v2[0]  = v1[NS];
  assign x2[0]  = x1[NS];
  assign y2[0]  = ky_end;
  assign z2[0]  = '0;
  assign p2[0]  = {z1[NS], flg1};

  for (genvar i = 0; i < NS; i++) begin : g_pitch
    dtpy_cell #(.STAGE(i), .PW(PW2)) u_cell (
      .clk (clk), .rst_n (rst_n), .en (en),
      .v_i (v2[i]), .x_i (x2[i]), .y_i (y2[i]), .z_i (z2[i]), .pay_i (p2[i]),
      .v_o (v2[i+1]), .x_o (x2[i+1]), .y_o (y2[i+1]), .z_o (z2[i+1]),
      .pay_o (p2[i+1])
    );
  end

  assign ya_end = p2[NS][PW2-1:FW];
  assign flg2   = p2[NS][FW-1:0];

  dtpy_finish #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_finish (
    .ya_i    (ya_end),
    .ea_i    (z2[NS]),
    .flg_i   (flg2),
    .pitch_o (pitch),
    .yaw_o   (yaw)
  );

  assign res_d = {6'd0, yaw, pitch};

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= v2[NS];
      end
    end else if (v2[NS] && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      if (skid_v_r) begin
        out_d_r <= skid_d_r;
        out_u_r <= skid_u_r;
      end else begin
        out_d_r <= res_d;
        out_u_r <= flg2.degen;
      end
    end else if (v2[NS] && en) begin
      skid_d_r <= res_d;
      skid_u_r <= flg2.degen;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_d_r;
  assign out_tuser[0] = out_u_r;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid stage full while output register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_tready |=> skid_v_r)
    else $error("skid stage lost a result while output stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_u_r |-> out_d_r == '0)
    else $error("zero vector result carries a non-zero angle");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    v2[NS] && en && out_v_r && !out_tready |=> skid_v_r)
    else $error("finished result not captured");

endmodule

`default_nettype wire
